[hdl/dq_pkg.sv]
// Package for the double-ended queue: sizes, command and status codes,
// payload types and the ring-pointer wrap function. No dependencies.
`default_nettype none

package dq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   // widths fixed by the request and response fields
   localparam int CMD_W   = 3;
   localparam int WORD_W  = 32;
   localparam int IDX_W   = 4;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (IDX_W > CNT_W) ? IDX_W : CNT_W;

   typedef logic [CMD_W-1:0]      cmd_type;
   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [STAT_W-1:0]     stat_type;
   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [CMP_W-1:0]      cmp_type;
   typedef logic [CNT_W:0]        sum_type;

   localparam cmd_type CMD_PUSH_FRONT = 3'd0;
   localparam cmd_type CMD_PUSH_BACK  = 3'd1;
   localparam cmd_type CMD_POP_FRONT  = 3'd2;
   localparam cmd_type CMD_POP_BACK   = 3'd3;
   localparam cmd_type CMD_PEEK_FRONT = 3'd4;
   localparam cmd_type CMD_PEEK_BACK  = 3'd5;
   localparam cmd_type CMD_GET        = 3'd6;
   localparam cmd_type CMD_CLEAR      = 3'd7;

   localparam stat_type ST_OK    = 2'd0;
   localparam stat_type ST_EMPTY = 2'd1;
   localparam stat_type ST_FULL  = 2'd2;

   // memory access issued by the controller for one request
   typedef struct packed {
      logic     wr_en;
      logic     rd_en;
      addr_type addr;
   } mem_req_type;

   // response fields known at accept time, carried alongside the read
   typedef struct packed {
      logic      has_data;
      stat_type  status;
      count_type count;
      logic      empty_flag;
   } rsp_meta_type;

   // (base + off) mod DEPTH, with base < DEPTH and off <= DEPTH
   function automatic addr_type wrap_add(input addr_type base, input cnt_type off);
      sum_type s;
      s = sum_type'(base) + sum_type'(off);
      if (s >= sum_type'(DEPTH)) begin
         s = s - sum_type'(DEPTH);
      end
      return addr_type'(s);
   endfunction

endpackage

`default_nettype wire

[hdl/dq_if.sv]
// Valid/ready channel interfaces for queue requests and responses.
// Depends on dq_pkg for the payload types.
`default_nettype none

interface dq_req_if;
   logic              valid;
   logic              ready;
   dq_pkg::cmd_type   cmd;
   dq_pkg::word_type  data_in;
   dq_pkg::idx_type   index;

   modport source (output valid, cmd, data_in, index, input ready);
   modport sink   (input valid, cmd, data_in, index, output ready);
endinterface

interface dq_rsp_if;
   logic              valid;
   logic              ready;
   dq_pkg::word_type  read_data;
   dq_pkg::stat_type  status;
   dq_pkg::count_type count;
   logic              empty_flag;

   modport source (output valid, read_data, status, count, empty_flag, input ready);
   modport sink   (input valid, read_data, status, count, empty_flag, output ready);
endinterface

`default_nettype wire

[hdl/dq_ram.sv]
// Single-port synchronous RAM with registered read data.
// Generic; no package dependency.
`default_nettype none

module dq_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic                                  rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   output      logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[addr];
      end
   end

endmodule

`default_nettype wire

[hdl/dq_ctrl.sv]
// Ring pointer control: front pointer and element count, memory access
// and response fields for each accepted request. Depends on dq_pkg.
`default_nettype none

module dq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire dq_pkg::cmd_type  cmd,
   input  wire dq_pkg::idx_type  index,
   output dq_pkg::mem_req_type   mem_req,
   output dq_pkg::rsp_meta_type  meta
);

   dq_pkg::addr_type front_ff, front_in;
   dq_pkg::cnt_type  count_ff, count_in;
   dq_pkg::stat_type status;
   logic             full, empty;

   assign full  = (count_ff == dq_pkg::cnt_type'(dq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      front_in       = front_ff;
      count_in       = count_ff;
      status         = dq_pkg::ST_OK;
      mem_req.wr_en  = 1'b0;
      mem_req.rd_en  = 1'b0;
      mem_req.addr   = front_ff;
      case (cmd)
         dq_pkg::CMD_PUSH_FRONT: begin
            if (full) begin
               status = dq_pkg::ST_FULL;
            end else begin
               // step the front back one slot and store there
               mem_req.addr  = (front_ff == '0) ?
                               dq_pkg::addr_type'(dq_pkg::DEPTH - 1) :
                               front_ff - dq_pkg::addr_type'(1);
               mem_req.wr_en = 1'b1;
               front_in      = mem_req.addr;
               count_in      = count_ff + dq_pkg::cnt_type'(1);
            end
         end
         dq_pkg::CMD_PUSH_BACK: begin
            if (full) begin
               status = dq_pkg::ST_FULL;
            end else begin
               mem_req.addr  = dq_pkg::wrap_add(front_ff, count_ff);
               mem_req.wr_en = 1'b1;
               count_in      = count_ff + dq_pkg::cnt_type'(1);
            end
         end
         dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_PEEK_FRONT: begin
            if (empty) begin
               status = dq_pkg::ST_EMPTY;
            end else begin
               mem_req.rd_en = 1'b1;
               if (cmd == dq_pkg::CMD_POP_FRONT) begin
                  front_in = dq_pkg::wrap_add(front_ff, dq_pkg::cnt_type'(1));
                  count_in = count_ff - dq_pkg::cnt_type'(1);
               end
            end
         end
         dq_pkg::CMD_POP_BACK, dq_pkg::CMD_PEEK_BACK: begin
            if (empty) begin
               status = dq_pkg::ST_EMPTY;
            end else begin
               mem_req.addr  = dq_pkg::wrap_add(front_ff, count_ff - dq_pkg::cnt_type'(1));
               mem_req.rd_en = 1'b1;
               if (cmd == dq_pkg::CMD_POP_BACK) begin
                  count_in = count_ff - dq_pkg::cnt_type'(1);
               end
            end
         end
         dq_pkg::CMD_GET: begin
            if (dq_pkg::cmp_type'(index) >= dq_pkg::cmp_type'(count_ff)) begin
               status = dq_pkg::ST_EMPTY;
            end else begin
               // index is below the count here, so it fits the count width
               mem_req.addr  = dq_pkg::wrap_add(front_ff, dq_pkg::cnt_type'(index));
               mem_req.rd_en = 1'b1;
            end
         end
         default: begin
            front_in = '0;
            count_in = '0;
         end
      endcase
      // no access unless the request is actually taken
      mem_req.wr_en = mem_req.wr_en & accept;
      mem_req.rd_en = mem_req.rd_en & accept;
   end

   assign meta.has_data   = mem_req.rd_en;
   assign meta.status     = status;
   assign meta.count      = dq_pkg::count_type'(count_in);
   assign meta.empty_flag = (count_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[hdl/double_ended_queue.sv]
// Bounded double-ended queue of data words on a circular buffer.
//
// Requests arrive on req_ch (cmd, data_in, index) and each produces exactly
// one response on rsp_ch (read_data, status, count, empty_flag), in order.
// Both channels use valid/ready; a transfer happens on a clock edge with
// both high.
//
// The RAM read and the middle stage register at the accept edge, and the output
// register takes them when the middle stage advances, which waits while the
// receiver stalls a response still held there.
// Throughput: one request per cycle unless the receiver stalls, set by the single
// RAM port that each request uses at most once. A write at one accept edge is
// seen by a read at any later edge, so back-to-back requests need no forwarding.
//
// Reset clears the front pointer, the element count and both valid flags;
// RAM contents are left as they are and are only read once written.
// When the receiver stalls, the response holds in the output register, the
// pending read holds in the middle stage, and req_ch.ready drops while the
// middle stage holds a request that cannot move into the output register.
// Depends on dq_pkg, dq_if, dq_ram and dq_ctrl.
`default_nettype none

module double_ended_queue (
   input  wire logic clock,
   input  wire logic reset,
   dq_req_if.sink    req_ch,
   dq_rsp_if.source  rsp_ch
);

   dq_pkg::mem_req_type  mem_req;
   dq_pkg::rsp_meta_type meta;
   dq_pkg::rsp_meta_type mid_meta_ff;
   dq_pkg::data_type     ram_q;
   logic                 accept;
   logic                 mid_valid_ff, mid_valid_in;
   logic                 mid_advance;
   logic                 rsp_valid_ff, rsp_valid_in;
   dq_pkg::word_type     rsp_data_ff;
   dq_pkg::stat_type     rsp_status_ff;
   dq_pkg::count_type    rsp_count_ff;
   logic                 rsp_empty_ff;

   assign mid_advance  = mid_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !mid_valid_ff || mid_advance;
   assign accept       = req_ch.valid && req_ch.ready;

   dq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .cmd     (req_ch.cmd),
      .index   (req_ch.index),
      .mem_req (mem_req),
      .meta    (meta)
   );

   dq_ram #(
      .DEPTH (dq_pkg::DEPTH),
      .WIDTH (dq_pkg::DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (dq_pkg::data_type'(req_ch.data_in)),
      .rd_data (ram_q)
   );

   assign mid_valid_in = accept || (mid_valid_ff && !mid_advance);
   assign rsp_valid_in = mid_advance || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_meta_ff <= meta;
      end
      if (mid_advance) begin
         rsp_data_ff   <= mid_meta_ff.has_data ? dq_pkg::word_type'(ram_q) : '0;
         rsp_status_ff <= mid_meta_ff.status;
         rsp_count_ff  <= mid_meta_ff.count;
         rsp_empty_ff  <= mid_meta_ff.empty_flag;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_data  = rsp_data_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.count      = rsp_count_ff;
   assign rsp_ch.empty_flag = rsp_empty_ff;

endmodule

`default_nettype wire

[hdl/dq_checker.sv]
// Port-level assertions for the double-ended queue and their bind to the
// top level. Depends on dq_pkg.
`default_nettype none

module dq_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire dq_pkg::word_type  rsp_read_data,
   input wire dq_pkg::stat_type  rsp_status,
   input wire dq_pkg::count_type rsp_count,
   input wire logic              rsp_empty_flag
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_empty_flag == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == dq_pkg::ST_OK || rsp_status == dq_pkg::ST_EMPTY ||
                     rsp_status == dq_pkg::ST_FULL))
      else $error("undefined status code");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dq_pkg::ST_FULL |->
         rsp_count == dq_pkg::count_type'(dq_pkg::DEPTH) && rsp_read_data == '0)
      else $error("full status with room left or data returned");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == dq_pkg::ST_EMPTY |-> rsp_read_data == '0)
      else $error("data returned on an empty or out-of-range request");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_read_data  (rsp_ch.read_data),
   .rsp_status     (rsp_ch.status),
   .rsp_count      (rsp_ch.count),
   .rsp_empty_flag (rsp_ch.empty_flag)
);

`default_nettype wire
